// ----- rtl/core/bounded_integer_set_table_top_macros.svh -----
// ---------------------------------------------------------------------------
// Bounded integer set table: assertion macros
// Shared macros for the concurrent checks of the set table.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_TABLE_TOP_MACROS_SVH
`define BOUNDED_INTEGER_SET_TABLE_TOP_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define BIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that holds at every clock edge while reset is asserted.
`define BIST_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) !rst_ni |-> prop) else $error(msg);

`endif

// ----- rtl/core/bist_pkg.sv -----
// ---------------------------------------------------------------------------
// Bounded integer set table package
// Types, codes and reset constants shared by the set table modules.
// ---------------------------------------------------------------------------
package bist_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned CmdW          = 2;
  localparam int unsigned StatusW       = 3;
  localparam int unsigned CountW        = 5;
  localparam int unsigned CapW          = 5;
  localparam int unsigned OutDataW      = 8;

  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED   = 3'd0,
    ST_FOUND   = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4
  } status_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic              en;
    logic              remove;
    logic [ValueW-1:0] key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/bist_cell.sv -----
// ---------------------------------------------------------------------------
// Set table cell
// Holds one table entry, compares it against the broadcast key and passes
// the running match flag and its value along the chain.
// ---------------------------------------------------------------------------
module bist_cell (
  input  logic                          clk_i,
  input  bist_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          occ_i,
  input  logic                          wr_i,
  input  logic                          shift_i,
  input  logic [bist_pkg::ValueW-1:0]   next_elem_i,
  output logic [bist_pkg::ValueW-1:0]   elem_o,
  output logic                          shift_o
);
  import bist_pkg::*;

  logic [ValueW-1:0] elem_q, elem_d;
  logic              match;

  assign match   = occ_i && (elem_q == ctrl_i.key);
  // Set once the matching entry lies at or below this cell.
  assign shift_o = shift_i | match;
  assign elem_o  = elem_q;

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.en && wr_i) begin
      elem_d = ctrl_i.key;
    end else if (ctrl_i.en && ctrl_i.remove && shift_o) begin
      elem_d = next_elem_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

endmodule

// ----- rtl/core/bounded_integer_set_table_top.sv -----
// An input transaction is registered, then resolved in the BUSY state by the
// single compare-and-shift pass of the cell chain, whose result is registered;
// a new item is taken only once the pass is done, and a stalled output holds BUSY.
// Reset: asynchronous, active low; count clears to zero, capacity to 16.
// Table entries are not cleared; only entries below the count are compared.
// ---------------------------------------------------------------------------
// Bounded integer set table
// Packed set of distinct 32-bit values in a chain of compare cells, with
// add, remove and query commands and a configurable capacity.
// ---------------------------------------------------------------------------
module bounded_integer_set_table_top #(
  parameter int unsigned DEPTH = bist_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [bist_pkg::ValueW-1:0]     s_axis_tdata_i,   // [31:0] value
  input  logic [bist_pkg::CmdW-1:0]       s_axis_tuser_i,   // [1:0] command
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [bist_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [2:0] status, [7:3] count
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bist_pkg::CapW-1:0]       cfg_data_i
);
  import bist_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [CmdW-1:0]    cmd_q;
  logic [ValueW-1:0]  key_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CapW-1:0]    cap_q;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [CountW-1:0]  out_count_q;

  logic               go;
  logic               hit;
  logic               full;
  logic               add_ok;
  logic [LW-1:0]      limit;
  cell_ctrl_t         ctrl;

  logic [ValueW-1:0]  elem [DEPTH];
  logic [DEPTH:0]     shift;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, status_q};

  // The pass completes once the output register is free.
  assign go   = (state_q == S_BUSY) && (!out_valid_q || m_axis_tready_i);
  assign hit  = shift[DEPTH];

  assign limit  = (LW'(cap_q) < LW'(DEPTH)) ? LW'(cap_q) : LW'(DEPTH);
  assign full   = (LW'(count_q) >= limit);
  assign add_ok = (cmd_q == CMD_ADD) && !hit && !full;

  assign ctrl.en     = go;
  assign ctrl.remove = (cmd_q == CMD_REMOVE);
  assign ctrl.key    = key_q;

  assign shift[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ValueW-1:0] next_elem;
    if (i == DEPTH - 1) begin : g_last
      assign next_elem = elem[i];
    end else begin : g_mid
      assign next_elem = elem[i+1];
    end

    bist_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (count_q > CW'(i)),
      .wr_i        (add_ok && (count_q == CW'(i))),
      .shift_i     (shift[i]),
      .next_elem_i (next_elem),
      .elem_o      (elem[i]),
      .shift_o     (shift[i+1])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_ABSENT;
    case (cmd_q)
      CMD_ADD: begin
        if (hit) begin
          status_d = ST_FOUND;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ADDED;
          count_d  = count_q + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          status_d = ST_REMOVED;
          count_d  = count_q - CW'(1);
        end
      end
      CMD_QUERY: begin
        status_d = hit ? ST_FOUND : ST_ABSENT;
      end
      default: begin
        status_d = ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (go) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q <= s_axis_tuser_i;
      key_q <= s_axis_tdata_i;
    end
    if (go) begin
      status_q    <= status_d;
      out_count_q <= CountW'(count_d);
    end
  end

endmodule

// ----- rtl/core/bist_checker.sv -----
// ---------------------------------------------------------------------------
// Set table port checker
// Watches the ports of the set table and checks ordering and result codes.
// ---------------------------------------------------------------------------
`include "bounded_integer_set_table_top_macros.svh"

module bist_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [bist_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import bist_pkg::*;

  // Only one item is in flight: no new transaction right after one is taken.
  `BIST_ASSERT(a_one_in_flight, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o, "input accepted while an item is in flight")

  // A new result is only raised at the end of a pass, while input is held off.
  `BIST_ASSERT(a_result_after_pass, $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o), "result raised without a pending item")

  // Status codes beyond not present are never produced.
  `BIST_ASSERT(a_status_code, m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] <= ST_ABSENT), "invalid status code")

  // A stalled result keeps its contents.
  `BIST_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled result changed")

  `BIST_ASSERT_RST(a_reset_idle, !m_axis_tvalid_o, "result valid during reset")

endmodule

bind bounded_integer_set_table_top bist_checker u_bist_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/sv/tb_bounded_integer_set_table_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bounded integer set table testbench
// Drives add, remove, query and unused commands into the set table, with
// capacity changes between phases and random gaps on both stream sides.
// A tracker keeps its own copy of the table and checks every status and
// count in order.
// ---------------------------------------------------------------------------

class set_table_tracker;
  typedef struct {
    bist_pkg::status_e status;
    logic [4:0]        count;
    logic [1:0]        cmd;
    logic [31:0]       value;
  } set_reply_t;

  logic [31:0] members[bist_pkg::DEPTH_DEFAULT];
  int unsigned member_count;
  logic [4:0]  capacity;
  set_reply_t  expected_replies[$];
  int unsigned failures;

  function new();
    member_count = 0;
    capacity     = bist_pkg::CAP_RESET;
    failures     = 0;
  endfunction

  function int find_member(logic [31:0] value);
    for (int i = 0; i < member_count; i++) begin
      if (members[i] === value) return i;
    end
    return -1;
  endfunction

  function int unsigned pending();
    return expected_replies.size();
  endfunction

  // Updates the table copy for one accepted command and queues its reply.
  function void note_command(logic [1:0] cmd, logic [31:0] value);
    set_reply_t  r;
    int          pos;
    int unsigned room;
    room     = (capacity > bist_pkg::DEPTH_DEFAULT) ? bist_pkg::DEPTH_DEFAULT : capacity;
    pos      = find_member(value);
    r.status = bist_pkg::ST_ABSENT;
    case (cmd)
      bist_pkg::CMD_ADD: begin
        // Presence is checked before the capacity limit.
        if (pos >= 0) begin
          r.status = bist_pkg::ST_FOUND;
        end else if (member_count >= room) begin
          r.status = bist_pkg::ST_FULL;
        end else begin
          members[member_count] = value;
          member_count++;
          r.status = bist_pkg::ST_ADDED;
        end
      end
      bist_pkg::CMD_REMOVE: begin
        if (pos >= 0) begin
          for (int j = pos; j + 1 < member_count; j++) members[j] = members[j + 1];
          member_count--;
          r.status = bist_pkg::ST_REMOVED;
        end
      end
      bist_pkg::CMD_QUERY: begin
        if (pos >= 0) r.status = bist_pkg::ST_FOUND;
      end
      default: begin
      end
    endcase
    r.count = member_count[4:0];
    r.cmd   = cmd;
    r.value = value;
    expected_replies.push_back(r);
  endfunction

  function void check_reply(logic [2:0] status, logic [4:0] count);
    set_reply_t r;
    if (expected_replies.size() == 0) begin
      $display("%0t: unexpected result, status %0d count %0d", $time, status, count);
      failures++;
      return;
    end
    r = expected_replies.pop_front();
    if (status !== r.status) begin
      $display("%0t: status mismatch (cmd %0d value %h): expected %0d, actual %0d",
               $time, r.cmd, r.value, r.status, status);
      failures++;
    end
    if (count !== r.count) begin
      $display("%0t: count mismatch (cmd %0d value %h): expected %0d, actual %0d",
               $time, r.cmd, r.value, r.count, count);
      failures++;
    end
  endfunction
endclass

module tb_bounded_integer_set_table_top;
  import bist_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [ValueW-1:0]   s_axis_tdata_i;   // [31:0] value
  logic [CmdW-1:0]     s_axis_tuser_i;   // [1:0] command
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;   // [2:0] status, [7:3] count
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CapW-1:0]     cfg_data_i;

  set_table_tracker tracker;
  logic             calm_phase;
  int unsigned      ready_hold;
  int unsigned      quiet_cycles;

  bounded_integer_set_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      m_axis_tready_i = 1'b0;
      ready_hold--;
    end else begin
      m_axis_tready_i = 1'b1;
      if ($urandom_range(0, 99) < 25) ready_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_reply(m_axis_tdata_o[2:0], m_axis_tdata_o[7:3]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bounded_integer_set_table_top");
      $finish;
    end
  end

  task automatic push_command(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = value;
    s_axis_tuser_i  = cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_command(cmd, value);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every queued reply has been checked.
  task automatic await_drain();
    s_axis_tvalid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] cap);
    await_drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.capacity = cap;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    int unsigned       phase_cap[PHASES] = '{16, 31, 1, 17, 8, 0, 0, 16};
    int unsigned       phase_add[PHASES] = '{70, 60, 50, 45, 55, 50, 40, 45};
    int unsigned       phase_rem[PHASES] = '{10, 20, 25, 30, 20, 25, 35, 25};
    logic [ValueW-1:0] value_pool[$];
    logic [ValueW-1:0] value;
    logic [CmdW-1:0]   cmd;
    int unsigned       r;

    tracker         = new();
    calm_phase      = 1'b0;
    ready_hold      = 0;
    quiet_cycles    = 0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_ADD;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty set, extreme values, duplicate add, removal from the front and
    // the back, and the unused command.
    push_command(CMD_QUERY, 32'h0000_0000);
    push_command(CMD_REMOVE, 32'h0000_0005);
    push_command(CMD_ADD, 32'h8000_0000);
    push_command(CMD_ADD, 32'h7FFF_FFFF);
    push_command(CMD_ADD, 32'h0000_0000);
    push_command(CMD_ADD, 32'hFFFF_FFFF);
    push_command(CMD_ADD, 32'h7FFF_FFFF);
    push_command(CMD_QUERY, 32'h8000_0000);
    push_command(CMD_UNUSED, 32'h8000_0000);
    push_command(CMD_REMOVE, 32'h8000_0000);
    push_command(CMD_QUERY, 32'hFFFF_FFFF);
    push_command(CMD_REMOVE, 32'hFFFF_FFFF);
    push_command(CMD_QUERY, 32'h8000_0000);
    push_command(CMD_UNUSED, 32'hFFFF_FFFF);

    // Capacity below the count: adds are full, but a present value is found.
    write_capacity(5'd1);
    push_command(CMD_ADD, 32'h5555_AAAA);
    push_command(CMD_ADD, 32'h0000_0000);
    push_command(CMD_REMOVE, 32'h0000_0000);
    push_command(CMD_ADD, 32'h5555_AAAA);
    write_capacity(5'd0);
    push_command(CMD_ADD, 32'hAAAA_5555);
    push_command(CMD_QUERY, 32'h7FFF_FFFF);
    push_command(CMD_REMOVE, 32'h7FFF_FFFF);
    push_command(CMD_ADD, 32'h0000_0001);
    // Capacity above the table depth is limited to the depth.
    write_capacity(5'd31);
    push_command(CMD_ADD, 32'hAAAA_5555);

    phase_cap[5] = $urandom_range(0, 31);
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p][CapW-1:0]);
      calm_phase = (p == 3);
      // A small pool makes duplicates, hits and a full table likely.
      value_pool.delete();
      value_pool.push_back(32'h0000_0000);
      value_pool.push_back(32'h0000_0001);
      value_pool.push_back(32'hFFFF_FFFF);
      value_pool.push_back(32'h8000_0000);
      value_pool.push_back(32'h7FFF_FFFF);
      repeat ($urandom_range(14, 20)) value_pool.push_back($urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) await_drain();
        r = $urandom_range(0, 99);
        if (r < phase_add[p]) begin
          cmd = CMD_ADD;
        end else if (r < phase_add[p] + phase_rem[p]) begin
          cmd = CMD_REMOVE;
        end else if (r < 93) begin
          cmd = CMD_QUERY;
        end else begin
          cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 99) < 85) begin
          value = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else begin
          value = $urandom();
        end
        push_command(cmd, value);
      end
    end
    calm_phase = 1'b0;

    await_drain();
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASS bounded_integer_set_table_top");
    end else begin
      $display("FAIL bounded_integer_set_table_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bist_pkg.sv
rtl/core/bist_cell.sv
rtl/core/bounded_integer_set_table_top.sv
rtl/core/bist_checker.sv
tb/sv/tb_bounded_integer_set_table_top.sv
